/* rtl/ntt_pkg.sv */
// Shared types and constants of the number theoretic transform unit.
package ntt_pkg;

    localparam int WORD_W         = 31;
    localparam int RESULT_INDEX_W = 10;
    localparam int LOG_LENGTH_W   = 4;
    localparam int CFG_INDEX_W    = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODULUS      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORWARD_ROOT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERSE_ROOT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOG_LENGTH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERSE_MODE = 3'd4;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } mm_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] value;
    } mm_rsp_t;

endpackage

/* rtl/ntt_mulmod.sv */
// Bit-serial modular multiplier: one bit of the first operand per cycle.
module ntt_mulmod
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ntt_pkg::mm_req_t              req,
    input  logic [ntt_pkg::WORD_W-1:0]    modulus,
    output ntt_pkg::mm_rsp_t              rsp
);
    import ntt_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] r_reg;
    logic [WORD_W-1:0] r_next;
    logic [WORD_W:0]   dbl;
    logic [WORD_W:0]   acc;

    always_comb
    begin
        dbl = {r_reg, 1'b0};
        if (dbl >= {1'b0, modulus})
        begin
            dbl = dbl - {1'b0, modulus};
        end
        acc = dbl + (a_reg[WORD_W-1] ? {1'b0, b_reg} : '0);
        if (acc >= {1'b0, modulus})
        begin
            acc = acc - {1'b0, modulus};
        end
        r_next = acc[WORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            a_reg <= {a_reg[WORD_W-2:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = r_reg;

endmodule

/* rtl/number_theoretic_transform_unit.sv */
// Top level of the radix-2 number theoretic transform unit.
// Input words: tuser selects the kind. A load word (kind 0) writes the next
// coefficient, reduced by the modulus through the bit-serial modular
// multiplier, into the coefficient memory. The load that completes
// 2^log_length coefficients (log_length read as 1 when zero and capped at
// log2(MAX_LENGTH)) starts the transform: bit-reversal, one modular
// exponentiation per stage (square and multiply on the serial multiplier),
// then the butterflies, each with two serial multiplies (product and twiddle
// update) plus the memory reads and write-back, only the product for the last
// one of each group. In inverse mode a scaling pass by n^(modulus-2) follows.
// A read word (kind 1) returns the next result via memory and output register
// when results are ready, and nothing otherwise. The input side is ready only
// while no load, read or transform is in progress; a result held in the output
// register does not block loads, and a stalled receiver holds the next read.
// Reset clears the counters and the ready flag and restores the register
// defaults; the memory contents stay undefined until written.
module number_theoretic_transform_unit
#(
    parameter int MAX_LENGTH = 1024
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,  // coefficient[30:0], zero pad
    input  logic                              s_tuser,  // kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [47:0]                       m_tdata,  // result_value, result_index, pad
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [ntt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ntt_pkg::WORD_W-1:0]        cfg_data
);
    import ntt_pkg::*;

    localparam int MAXLG  = $clog2(MAX_LENGTH + 1) - 1;
    localparam int ADDR_W = MAXLG;
    localparam int CNT_W  = ADDR_W + 1;
    localparam int LG_W   = $clog2(MAXLG + 2);
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int ST_W   = 5;

    localparam logic [ST_W-1:0] S_IDLE    = 5'd0;
    localparam logic [ST_W-1:0] S_LD_WR   = 5'd1;
    localparam logic [ST_W-1:0] S_RD_WAIT = 5'd2;
    localparam logic [ST_W-1:0] S_RD_OUT  = 5'd3;
    localparam logic [ST_W-1:0] S_MULW    = 5'd4;
    localparam logic [ST_W-1:0] S_PR_ROOT = 5'd5;
    localparam logic [ST_W-1:0] S_BR_A    = 5'd6;
    localparam logic [ST_W-1:0] S_BR_B    = 5'd7;
    localparam logic [ST_W-1:0] S_BR_C    = 5'd8;
    localparam logic [ST_W-1:0] S_BR_D    = 5'd9;
    localparam logic [ST_W-1:0] S_ST      = 5'd10;
    localparam logic [ST_W-1:0] S_PW      = 5'd11;
    localparam logic [ST_W-1:0] S_PW_M1   = 5'd12;
    localparam logic [ST_W-1:0] S_PW_SQ   = 5'd13;
    localparam logic [ST_W-1:0] S_PW_M2   = 5'd14;
    localparam logic [ST_W-1:0] S_BF0     = 5'd15;
    localparam logic [ST_W-1:0] S_BF_RU   = 5'd16;
    localparam logic [ST_W-1:0] S_BF_RV   = 5'd17;
    localparam logic [ST_W-1:0] S_BF_MUL  = 5'd18;
    localparam logic [ST_W-1:0] S_BF_WR1  = 5'd19;
    localparam logic [ST_W-1:0] S_BF_WR2  = 5'd20;
    localparam logic [ST_W-1:0] S_BF_W2   = 5'd21;
    localparam logic [ST_W-1:0] S_SC0     = 5'd22;
    localparam logic [ST_W-1:0] S_SC1     = 5'd23;
    localparam logic [ST_W-1:0] S_SC2     = 5'd24;
    localparam logic [ST_W-1:0] S_SC_RD   = 5'd25;
    localparam logic [ST_W-1:0] S_SC_Q    = 5'd26;
    localparam logic [ST_W-1:0] S_SC_WR   = 5'd27;

    logic [WORD_W-1:0]       modulus_reg;
    logic [WORD_W-1:0]       forward_root_reg;
    logic [WORD_W-1:0]       inverse_root_reg;
    logic [LOG_LENGTH_W-1:0] log_length_reg;
    logic                    inverse_mode_reg;

    logic [ST_W-1:0]   state_reg, state_next;
    logic [ST_W-1:0]   ret_reg, ret_next;
    logic [ST_W-1:0]   pw_ret_reg, pw_ret_next;
    logic [CNT_W-1:0]  load_count_reg, load_count_next;
    logic [ADDR_W-1:0] read_count_reg, read_count_next;
    logic              results_ready_reg, results_ready_next;
    logic [LG_W-1:0]   lg_reg, lg_next;
    logic [LG_W-1:0]   hlog_reg, hlog_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [WORD_W-1:0] root_reg, root_next;
    logic [WORD_W-1:0] gn_reg, gn_next;
    logic [WORD_W-1:0] w_reg, w_next;
    logic [WORD_W-1:0] u_reg, u_next;
    logic [WORD_W-1:0] scale_reg, scale_next;
    logic [WORD_W-1:0] pw_base_reg, pw_base_next;
    logic [WORD_W-1:0] pw_exp_reg, pw_exp_next;
    logic [WORD_W-1:0] pw_res_reg, pw_res_next;
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] m_value_reg, m_value_next;
    logic [RESULT_INDEX_W-1:0] m_index_reg, m_index_next;
    logic              m_last_reg, m_last_next;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] q_reg;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [WORD_W-1:0] mem_wdata;

    mm_req_t           mm_req;
    mm_rsp_t           mm_rsp;

    logic [WORD_W-1:0] meff;
    logic [WORD_W-1:0] one;
    logic [LG_W-1:0]   lg_cur;
    logic [CNT_W-1:0]  n_cur;
    logic [CNT_W-1:0]  n_run;
    logic [CNT_W-1:0]  half;
    logic [ADDR_W-1:0] rev_full;
    logic [CNT_W-1:0]  rev_j;
    logic [WORD_W:0]   add_sum;
    logic [WORD_W:0]   sub_dif;
    logic [WORD_W-1:0] root_sel;
    logic [ADDR_W+RESULT_INDEX_W-1:0] idx_wide;

    always_comb
    begin
        meff = (modulus_reg == '0) ? WORD_W'(1) : modulus_reg;
        one  = (meff == WORD_W'(1)) ? '0 : WORD_W'(1);
        if (log_length_reg == '0)
        begin
            lg_cur = LG_W'(1);
        end
        else if (int'(log_length_reg) > MAXLG)
        begin
            lg_cur = LG_W'(MAXLG);
        end
        else
        begin
            lg_cur = LG_W'(log_length_reg);
        end
        n_cur = CNT_W'(1) << lg_cur;
        n_run = CNT_W'(1) << lg_reg;
        half  = CNT_W'(1) << (hlog_reg - LG_W'(1));
        for (int b = 0; b < ADDR_W; b++)
        begin
            rev_full[b] = i_reg[ADDR_W-1-b];
        end
        rev_j    = {1'b0, rev_full} >> (LG_W'(ADDR_W) - lg_reg);
        add_sum  = {1'b0, u_reg} + {1'b0, mm_rsp.value};
        if (add_sum >= {1'b0, meff})
        begin
            add_sum = add_sum - {1'b0, meff};
        end
        sub_dif  = {1'b0, u_reg} + {1'b0, meff} - {1'b0, mm_rsp.value};
        if (u_reg >= mm_rsp.value)
        begin
            sub_dif = {1'b0, u_reg} - {1'b0, mm_rsp.value};
        end
        root_sel = inverse_mode_reg ? inverse_root_reg : forward_root_reg;
        idx_wide = {RESULT_INDEX_W'(0), read_count_reg};
    end

    ntt_mulmod u_mulmod
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mm_req),
        .modulus (meff),
        .rsp     (mm_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            q_reg <= mem[mem_addr];
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        ret_next           = ret_reg;
        pw_ret_next        = pw_ret_reg;
        load_count_next    = load_count_reg;
        read_count_next    = read_count_reg;
        results_ready_next = results_ready_reg;
        lg_next            = lg_reg;
        hlog_next          = hlog_reg;
        i_next             = i_reg;
        k_next             = k_reg;
        j_next             = j_reg;
        root_next          = root_reg;
        gn_next            = gn_reg;
        w_next             = w_reg;
        u_next             = u_reg;
        scale_next         = scale_reg;
        pw_base_next       = pw_base_reg;
        pw_exp_next        = pw_exp_reg;
        pw_res_next        = pw_res_reg;
        m_valid_next       = m_valid_reg;
        m_value_next       = m_value_reg;
        m_index_next       = m_index_reg;
        m_last_next        = m_last_reg;
        mem_we             = 1'b0;
        mem_re             = 1'b0;
        mem_addr           = '0;
        mem_wdata          = '0;
        mm_req.start       = 1'b0;
        mm_req.a           = '0;
        mm_req.b           = '0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == KIND_LOAD)
                    begin
                        results_ready_next = 1'b0;
                        read_count_next    = '0;
                        mm_req.start       = 1'b1;
                        mm_req.a           = s_tdata[WORD_W-1:0];
                        mm_req.b           = one;
                        ret_next           = S_LD_WR;
                        state_next         = S_MULW;
                    end
                    else if (results_ready_reg)
                    begin
                        mem_re     = 1'b1;
                        mem_addr   = read_count_reg;
                        state_next = S_RD_WAIT;
                    end
                end
            end
            S_MULW:
            begin
                if (mm_rsp.done)
                begin
                    state_next = ret_reg;
                end
            end
            S_LD_WR:
            begin
                mem_we          = 1'b1;
                mem_addr        = load_count_reg[ADDR_W-1:0];
                mem_wdata       = mm_rsp.value;
                load_count_next = load_count_reg + 1'b1;
                if (load_count_next >= n_cur)
                begin
                    load_count_next = '0;
                    lg_next         = lg_cur;
                    mm_req.start    = 1'b1;
                    mm_req.a        = root_sel;
                    mm_req.b        = one;
                    ret_next        = S_PR_ROOT;
                    state_next      = S_MULW;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD_WAIT:
            begin
                state_next = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_value_next = q_reg;
                    m_index_next = idx_wide[RESULT_INDEX_W-1:0];
                    m_last_next  = ({1'b0, read_count_reg} + 1'b1) >= n_cur;
                    if (m_last_next)
                    begin
                        results_ready_next = 1'b0;
                        read_count_next    = '0;
                    end
                    else
                    begin
                        read_count_next = read_count_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_PR_ROOT:
            begin
                root_next  = mm_rsp.value;
                i_next     = '0;
                state_next = S_BR_A;
            end
            S_BR_A:
            begin
                if (i_reg == n_run)
                begin
                    hlog_next  = LG_W'(1);
                    state_next = S_ST;
                end
                else if (i_reg < rev_j)
                begin
                    mem_re     = 1'b1;
                    mem_addr   = i_reg[ADDR_W-1:0];
                    state_next = S_BR_B;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_BR_B:
            begin
                mem_re     = 1'b1;
                mem_addr   = rev_j[ADDR_W-1:0];
                u_next     = q_reg;
                state_next = S_BR_C;
            end
            S_BR_C:
            begin
                mem_we     = 1'b1;
                mem_addr   = i_reg[ADDR_W-1:0];
                mem_wdata  = q_reg;
                state_next = S_BR_D;
            end
            S_BR_D:
            begin
                mem_we     = 1'b1;
                mem_addr   = rev_j[ADDR_W-1:0];
                mem_wdata  = u_reg;
                i_next     = i_reg + 1'b1;
                state_next = S_BR_A;
            end
            S_ST:
            begin
                if (hlog_reg > lg_reg)
                begin
                    if (inverse_mode_reg)
                    begin
                        state_next = S_SC0;
                    end
                    else
                    begin
                        results_ready_next = 1'b1;
                        read_count_next    = '0;
                        state_next         = S_IDLE;
                    end
                end
                else
                begin
                    pw_base_next = root_reg;
                    pw_exp_next  = (meff - 1'b1) >> hlog_reg;
                    pw_res_next  = one;
                    pw_ret_next  = S_BF0;
                    state_next   = S_PW;
                end
            end
            S_PW:
            begin
                if (pw_exp_reg == '0)
                begin
                    state_next = pw_ret_reg;
                end
                else if (pw_exp_reg[0])
                begin
                    mm_req.start = 1'b1;
                    mm_req.a     = pw_res_reg;
                    mm_req.b     = pw_base_reg;
                    ret_next     = S_PW_M1;
                    state_next   = S_MULW;
                end
                else
                begin
                    state_next = S_PW_SQ;
                end
            end
            S_PW_M1:
            begin
                pw_res_next = mm_rsp.value;
                state_next  = S_PW_SQ;
            end
            S_PW_SQ:
            begin
                mm_req.start = 1'b1;
                mm_req.a     = pw_base_reg;
                mm_req.b     = pw_base_reg;
                ret_next     = S_PW_M2;
                state_next   = S_MULW;
            end
            S_PW_M2:
            begin
                pw_base_next = mm_rsp.value;
                pw_exp_next  = pw_exp_reg >> 1;
                state_next   = S_PW;
            end
            S_BF0:
            begin
                gn_next    = pw_res_reg;
                k_next     = '0;
                j_next     = '0;
                w_next     = one;
                state_next = S_BF_RU;
            end
            S_BF_RU:
            begin
                if (k_reg >= n_run)
                begin
                    hlog_next  = hlog_reg + 1'b1;
                    state_next = S_ST;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_addr   = k_reg[ADDR_W-1:0];
                    state_next = S_BF_RV;
                end
            end
            S_BF_RV:
            begin
                mem_re     = 1'b1;
                mem_addr   = ADDR_W'(k_reg + half);
                u_next     = q_reg;
                state_next = S_BF_MUL;
            end
            S_BF_MUL:
            begin
                mm_req.start = 1'b1;
                mm_req.a     = q_reg;
                mm_req.b     = w_reg;
                ret_next     = S_BF_WR1;
                state_next   = S_MULW;
            end
            S_BF_WR1:
            begin
                mem_we     = 1'b1;
                mem_addr   = k_reg[ADDR_W-1:0];
                mem_wdata  = add_sum[WORD_W-1:0];
                state_next = S_BF_WR2;
            end
            S_BF_WR2:
            begin
                mem_we    = 1'b1;
                mem_addr  = ADDR_W'(k_reg + half);
                mem_wdata = sub_dif[WORD_W-1:0];
                if (j_reg + 1'b1 == half)
                begin
                    j_next     = '0;
                    k_next     = k_reg + 1'b1 + half;
                    w_next     = one;
                    state_next = S_BF_RU;
                end
                else
                begin
                    j_next       = j_reg + 1'b1;
                    k_next       = k_reg + 1'b1;
                    mm_req.start = 1'b1;
                    mm_req.a     = w_reg;
                    mm_req.b     = gn_reg;
                    ret_next     = S_BF_W2;
                    state_next   = S_MULW;
                end
            end
            S_BF_W2:
            begin
                w_next     = mm_rsp.value;
                state_next = S_BF_RU;
            end
            S_SC0:
            begin
                mm_req.start = 1'b1;
                mm_req.a     = WORD_W'(n_run);
                mm_req.b     = one;
                ret_next     = S_SC1;
                state_next   = S_MULW;
            end
            S_SC1:
            begin
                pw_base_next = mm_rsp.value;
                pw_exp_next  = (meff >= WORD_W'(2)) ? meff - WORD_W'(2) : '0;
                pw_res_next  = one;
                pw_ret_next  = S_SC2;
                state_next   = S_PW;
            end
            S_SC2:
            begin
                scale_next = pw_res_reg;
                i_next     = '0;
                state_next = S_SC_RD;
            end
            S_SC_RD:
            begin
                if (i_reg == n_run)
                begin
                    results_ready_next = 1'b1;
                    read_count_next    = '0;
                    state_next         = S_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_addr   = i_reg[ADDR_W-1:0];
                    state_next = S_SC_Q;
                end
            end
            S_SC_Q:
            begin
                mm_req.start = 1'b1;
                mm_req.a     = q_reg;
                mm_req.b     = scale_reg;
                ret_next     = S_SC_WR;
                state_next   = S_MULW;
            end
            S_SC_WR:
            begin
                mem_we     = 1'b1;
                mem_addr   = i_reg[ADDR_W-1:0];
                mem_wdata  = mm_rsp.value;
                i_next     = i_reg + 1'b1;
                state_next = S_SC_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg       <= WORD_W'(998244353);
            forward_root_reg  <= WORD_W'(3);
            inverse_root_reg  <= WORD_W'(332748118);
            log_length_reg    <= LOG_LENGTH_W'(10);
            inverse_mode_reg  <= 1'b0;
            state_reg         <= S_IDLE;
            ret_reg           <= S_IDLE;
            pw_ret_reg        <= S_IDLE;
            load_count_reg    <= '0;
            read_count_reg    <= '0;
            results_ready_reg <= 1'b0;
            m_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODULUS:      modulus_reg      <= cfg_data;
                    CFG_FORWARD_ROOT: forward_root_reg <= cfg_data;
                    CFG_INVERSE_ROOT: inverse_root_reg <= cfg_data;
                    CFG_LOG_LENGTH:   log_length_reg   <= cfg_data[LOG_LENGTH_W-1:0];
                    CFG_INVERSE_MODE: inverse_mode_reg <= cfg_data[0];
                    default:          ;
                endcase
            end
            state_reg         <= state_next;
            ret_reg           <= ret_next;
            pw_ret_reg        <= pw_ret_next;
            load_count_reg    <= load_count_next;
            read_count_reg    <= read_count_next;
            results_ready_reg <= results_ready_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lg_reg      <= lg_next;
        hlog_reg    <= hlog_next;
        i_reg       <= i_next;
        k_reg       <= k_next;
        j_reg       <= j_next;
        root_reg    <= root_next;
        gn_reg      <= gn_next;
        w_reg       <= w_next;
        u_reg       <= u_next;
        scale_reg   <= scale_next;
        pw_base_reg <= pw_base_next;
        pw_exp_reg  <= pw_exp_next;
        pw_res_reg  <= pw_res_next;
        m_value_reg <= m_value_next;
        m_index_reg <= m_index_next;
        m_last_reg  <= m_last_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_index_reg, m_value_reg};
    assign m_tlast  = m_last_reg;

endmodule

/* sim/number_theoretic_transform_unit_checker.sv */
// Checker that predicts and compares the result words of the transform unit.
module number_theoretic_transform_unit_checker
    import ntt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [31:0]            s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [47:0]            m_tdata,
    input  logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data,
    output int                     fault_count,
    output int                     pending,
    output int                     results_checked
);

    typedef struct {
        bit [WORD_W-1:0]         value;
        bit [RESULT_INDEX_W-1:0] index;
        bit                      last;
    } ntt_result_t;

    localparam int STORE_DEPTH = 1024;

    ntt_result_t         expected_results[$];
    bit [WORD_W-1:0]     coeff_store[STORE_DEPTH];
    bit [WORD_W-1:0]     reg_modulus;
    bit [WORD_W-1:0]     reg_forward_root;
    bit [WORD_W-1:0]     reg_inverse_root;
    bit [LOG_LENGTH_W-1:0] reg_log_length;
    bit                  reg_inverse_mode;
    int                  loaded;
    int                  read_pos;
    bit                  results_ready;
    int                  faults;
    int                  checked;

    function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b,
                                                longint unsigned m);
        return (a * b) % m;
    endfunction

    function automatic longint unsigned mod_pow(longint unsigned base, longint unsigned e,
                                                longint unsigned m);
        longint unsigned r;
        r = 1 % m;
        base = base % m;
        while (e != 0)
        begin
            if (e[0])
                r = mod_mul(r, base, m);
            base = mod_mul(base, base, m);
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic int length_log();
        if (reg_log_length < 1)
            return 1;
        if (reg_log_length > 10)
            return 10;
        return reg_log_length;
    endfunction

    function automatic longint unsigned active_modulus();
        return (reg_modulus == 0) ? 1 : reg_modulus;
    endfunction

    task automatic transform_store(int n, int lg);
        longint unsigned m;
        longint unsigned root;
        longint unsigned gn;
        longint unsigned w;
        longint unsigned u;
        longint unsigned t;
        longint unsigned scale;
        bit [WORD_W-1:0] tmp;
        int j;
        m = active_modulus();
        for (int i = 0; i < n; i++)
        begin
            j = 0;
            for (int b = 0; b < lg; b++)
                j = (j << 1) | ((i >> b) & 1);
            if (i < j)
            begin
                tmp = coeff_store[i];
                coeff_store[i] = coeff_store[j];
                coeff_store[j] = tmp;
            end
        end
        root = reg_inverse_mode ? reg_inverse_root : reg_forward_root;
        for (int h = 2; h <= n; h = h << 1)
        begin
            gn = mod_pow(root, (m - 1) / h, m);
            for (int s = 0; s < n; s += h)
            begin
                w = 1 % m;
                for (int k = s; k < s + h / 2; k++)
                begin
                    u = coeff_store[k] % m;
                    t = mod_mul(w, coeff_store[k + h / 2] % m, m);
                    coeff_store[k] = (u + t) % m;
                    coeff_store[k + h / 2] = (u + m - t) % m;
                    w = mod_mul(w, gn, m);
                end
            end
        end
        if (reg_inverse_mode)
        begin
            scale = mod_pow(n % m, (m >= 2) ? m - 2 : 0, m);
            for (int i = 0; i < n; i++)
                coeff_store[i] = mod_mul(coeff_store[i], scale, m);
        end
    endtask

    task automatic predict_word(bit kind, bit [WORD_W-1:0] coeff);
        int lg;
        int n;
        ntt_result_t r;
        lg = length_log();
        n = 1 << lg;
        if (kind == KIND_LOAD)
        begin
            results_ready = 0;
            read_pos = 0;
            if (loaded < STORE_DEPTH)
                coeff_store[loaded] = coeff % active_modulus();
            loaded++;
            if (loaded >= n)
            begin
                transform_store(n, lg);
                loaded = 0;
                results_ready = 1;
            end
        end
        else if (results_ready)
        begin
            r.value = coeff_store[read_pos];
            r.index = read_pos;
            r.last = (read_pos + 1) >= n;
            expected_results.push_back(r);
            if (r.last)
            begin
                results_ready = 0;
                read_pos = 0;
            end
            else
            begin
                read_pos++;
            end
        end
    endtask

    task automatic compare_word();
        ntt_result_t r;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result word: value %0d index %0d last %0d",
                   m_tdata[30:0], m_tdata[40:31], m_tlast);
            faults++;
            return;
        end
        r = expected_results.pop_front();
        checked++;
        if (m_tdata[30:0] !== r.value)
        begin
            $error("result_value mismatch: expected %0d, got %0d", r.value, m_tdata[30:0]);
            faults++;
        end
        if (m_tdata[40:31] !== r.index)
        begin
            $error("result_index mismatch: expected %0d, got %0d", r.index, m_tdata[40:31]);
            faults++;
        end
        if (m_tlast !== r.last)
        begin
            $error("last mismatch: expected %0d, got %0d", r.last, m_tlast);
            faults++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            reg_modulus = 998244353;
            reg_forward_root = 3;
            reg_inverse_root = 332748118;
            reg_log_length = 10;
            reg_inverse_mode = 0;
            loaded = 0;
            read_pos = 0;
            results_ready = 0;
            faults = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODULUS:      reg_modulus = cfg_data;
                    CFG_FORWARD_ROOT: reg_forward_root = cfg_data;
                    CFG_INVERSE_ROOT: reg_inverse_root = cfg_data;
                    CFG_LOG_LENGTH:   reg_log_length = cfg_data[LOG_LENGTH_W-1:0];
                    CFG_INVERSE_MODE: reg_inverse_mode = cfg_data[0];
                    default:          ;
                endcase
            end
            if (m_tvalid && m_tready)
                compare_word();
            if (s_tvalid && s_tready)
                predict_word(s_tuser, s_tdata[30:0]);
        end
        fault_count <= faults;
        pending <= expected_results.size();
        results_checked <= checked;
    end

endmodule

/* sim/number_theoretic_transform_unit_tb.sv */
// Testbench top: stimulus, register settings and verdict for the transform unit.
module number_theoretic_transform_unit_tb;
    import ntt_pkg::*;

    localparam int IDLE_LIMIT = 1500000;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_WORDS = 770;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [31:0]            s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [47:0]            m_tdata;
    logic                   m_tlast;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [WORD_W-1:0]      cfg_data;

    int fault_count;
    int pending;
    int results_checked;
    int words_sent;
    int settings_used;
    int burst_left;
    int frame_len;
    int idle_cycles;
    int stall_mode;
    int stall_count;

    number_theoretic_transform_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    number_theoretic_transform_unit_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fault_count    (fault_count),
        .pending        (pending),
        .results_checked(results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (stall_count == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_count = $urandom_range(20, 80);
        end
        stall_count--;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("number_theoretic_transform_unit_tb: FAIL");
                $finish;
            end
        end
    end

    function automatic int length_of(int lg);
        if (lg < 1)
            return 2;
        if (lg > 10)
            return 1024;
        return 1 << lg;
    endfunction

    task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [WORD_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic configure(logic [WORD_W-1:0] modulus, logic [WORD_W-1:0] fwd_root,
                             logic [WORD_W-1:0] inv_root, int lg, logic inverse);
        put_reg(CFG_MODULUS, modulus);
        put_reg(CFG_FORWARD_ROOT, fwd_root);
        put_reg(CFG_INVERSE_ROOT, inv_root);
        put_reg(CFG_LOG_LENGTH, WORD_W'(lg));
        put_reg(CFG_INVERSE_MODE, WORD_W'(inverse));
        cfg_we <= 1'b0;
        frame_len = length_of(lg);
        settings_used++;
    endtask

    task automatic send_word(logic kind, logic [30:0] coeff);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {1'b0, coeff};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_frame(int reads);
        for (int i = 0; i < frame_len; i++)
            send_word(KIND_LOAD, 31'($urandom()));
        for (int i = 0; i < reads; i++)
            send_word(KIND_READ, 31'($urandom()));
    endtask

    logic [WORD_W-1:0] moduli[12] = '{998244353, 7681, 12289, 17, 257, 65537,
                                      2147483647, 3, 0, 1, 2, 469762049};

    initial
    begin
        int goal;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        words_sent = 0;
        settings_used = 0;
        burst_left = 0;
        idle_cycles = 0;
        stall_count = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at length two: extremes, reads with nothing ready,
        // and a new frame that discards results not yet read.
        configure(998244353, 3, 332748118, 1, 1'b0);
        send_word(KIND_READ, 31'h7FFFFFFF);
        send_word(KIND_LOAD, 31'h0);
        send_word(KIND_LOAD, 31'h7FFFFFFF);
        send_word(KIND_READ, 31'h0);
        send_word(KIND_READ, 31'h0);
        send_word(KIND_READ, 31'h0);
        send_word(KIND_LOAD, 31'd998244352);
        send_word(KIND_LOAD, 31'd1);
        send_word(KIND_READ, 31'h0);
        send_word(KIND_LOAD, 31'd5);
        send_word(KIND_LOAD, 31'd7);
        send_word(KIND_READ, 31'h0);
        send_word(KIND_READ, 31'h0);
        settle();

        // Length shortened part way through a frame.
        configure(12289, 11, 2147483646, 3, 1'b1);
        send_word(KIND_LOAD, 31'd100);
        send_word(KIND_LOAD, 31'd200);
        send_word(KIND_LOAD, 31'd300);
        settle();
        put_reg(CFG_LOG_LENGTH, WORD_W'(0));
        cfg_we <= 1'b0;
        frame_len = 2;
        send_word(KIND_LOAD, 31'd400);
        send_word(KIND_READ, 31'h0);
        send_word(KIND_READ, 31'h0);
        settle();

        configure(0, 2147483646, 1, 2, 1'b1);
        run_frame(4);
        settle();

        goal = words_sent + RANDOM_WORDS;
        while (words_sent < goal)
        begin
            configure(moduli[$urandom_range(0, 11)], WORD_W'($urandom()), WORD_W'($urandom()),
                      $urandom_range(0, 6), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 4))
            begin
                repeat ($urandom_range(0, 2)) send_word(KIND_READ, 31'($urandom()));
                if ($urandom_range(0, 4) == 0)
                    run_frame($urandom_range(1, frame_len - 1));
                else
                    run_frame(frame_len);
            end
            run_frame(frame_len);
            settle();
        end

        $display("Run covered %0d input words and %0d result words over %0d settings,",
                 words_sent, results_checked, settings_used);
        $display("lengths from 2 to 64 in forward and inverse mode.");
        if (fault_count == 0)
            $display("number_theoretic_transform_unit_tb: PASS");
        else
            $display("number_theoretic_transform_unit_tb: FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/ntt_pkg.sv
rtl/ntt_mulmod.sv
rtl/number_theoretic_transform_unit.sv
sim/number_theoretic_transform_unit_checker.sv
sim/number_theoretic_transform_unit_tb.sv
